@@ rtl/core/wph_pkg.sv @@
// Package for the WAV PCM header parser: widths, phase codes, tags,
// failure codes and the result struct. No dependencies.
`default_nettype none

package wph_pkg;

    localparam int LEN_W    = 20;   // byte position / total length width
    localparam int NCS_W    = 34;   // next chunk start, full width
    localparam int SUM_W    = NCS_W + 1;
    localparam int OFS_W    = 20;
    localparam int CNT_W    = 19;
    localparam int RATE_W   = 32;
    localparam int REASON_W = 3;

    localparam logic [2:0] PH_HEADER    = 3'd0;
    localparam logic [2:0] PH_WAIT      = 3'd1;
    localparam logic [2:0] PH_CHUNK_HDR = 3'd2;
    localparam logic [2:0] PH_FMT       = 3'd3;
    localparam logic [2:0] PH_IDLE      = 3'd4;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [LEN_W-1:0] MIN_FILE_BYTES = LEN_W'(44);
    localparam logic [NCS_W-1:0] FIRST_CHUNK    = NCS_W'(12);
    localparam logic [31:0]      FMT_MIN_BYTES  = 32'd16;

    localparam logic [REASON_W-1:0] FAIL_NONE    = 3'd0;
    localparam logic [REASON_W-1:0] FAIL_SHORT   = 3'd1;
    localparam logic [REASON_W-1:0] FAIL_TAGS    = 3'd2;
    localparam logic [REASON_W-1:0] FAIL_OVERRUN = 3'd3;
    localparam logic [REASON_W-1:0] FAIL_NO_PCM  = 3'd4;
    localparam logic [REASON_W-1:0] FAIL_EMPTY   = 3'd5;
    localparam logic [REASON_W-1:0] FAIL_NO_DATA = 3'd6;

    typedef struct packed {
        logic                valid;
        logic                found;
        logic [REASON_W-1:0] fail_reason;
        logic [OFS_W-1:0]    data_offset;
        logic [CNT_W-1:0]    num_samples;
        logic [RATE_W-1:0]   rate_hz;
    } wph_result_t;

endpackage

`default_nettype wire

@@ rtl/core/wph_parse_core.sv @@
// Parser state and per-byte step logic of the WAV PCM header parser.
// Depends on wph_pkg.
`default_nettype none

module wph_parse_core (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      step,
    input  wire logic [7:0]                in_byte,
    input  wire logic [wph_pkg::LEN_W-1:0] in_total,
    input  wire logic                      in_last,
    output wph_pkg::wph_result_t           res
);

    logic [wph_pkg::LEN_W-1:0] pos_reg, pos_next;
    logic [2:0]                phase_reg, phase_next;
    logic [31:0]               tag_reg, tag_next;
    logic [31:0]               len_reg, len_next;
    logic [wph_pkg::NCS_W-1:0] ncs_reg, ncs_next;
    logic [47:0]               ff_reg, ff_next;
    logic                      pcm_reg, pcm_next;
    logic [31:0]               rate_reg, rate_next;
    logic                      verdict_reg, verdict_next;

    logic [31:0]               tag_shift, len_shift;
    logic [wph_pkg::SUM_W-1:0] pay, chunk_end, hdr_start, fmt_start, total_ext, pos_ext;
    logic [2:0]                off;
    logic [3:0]                fp;

    function automatic wph_pkg::wph_result_t make_fail(input logic [2:0] code);
        wph_pkg::wph_result_t r;
        r             = '0;
        r.valid       = 1'b1;
        r.fail_reason = code;
        return r;
    endfunction

    assign tag_shift = {in_byte, tag_reg[31:8]};
    assign len_shift = {in_byte, len_reg[31:8]};
    assign total_ext = {{(wph_pkg::SUM_W-wph_pkg::LEN_W){1'b0}}, in_total};
    assign pos_ext   = {{(wph_pkg::SUM_W-wph_pkg::LEN_W){1'b0}}, pos_reg};
    assign pay       = {1'b0, ncs_reg} + wph_pkg::SUM_W'(8);
    assign chunk_end = pay + {3'b000, len_shift};
    assign hdr_start = chunk_end + {{(wph_pkg::SUM_W-1){1'b0}}, len_shift[0]};
    assign fmt_start = pay + {3'b000, len_reg} + {{(wph_pkg::SUM_W-1){1'b0}}, len_reg[0]};
    assign off       = pos_reg[2:0] - ncs_reg[2:0];
    assign fp        = pos_reg[3:0] - (ncs_reg[3:0] + 4'd8);

    always_comb
    begin
        logic hdr;
        pos_next     = pos_reg;
        phase_next   = phase_reg;
        tag_next     = tag_reg;
        len_next     = len_reg;
        ncs_next     = ncs_reg;
        ff_next      = ff_reg;
        pcm_next     = pcm_reg;
        rate_next    = rate_reg;
        verdict_next = verdict_reg;
        res          = '0;
        hdr          = 1'b0;
        if (step)
        begin
            if (!verdict_reg)
            begin
                case (phase_reg)
                    wph_pkg::PH_HEADER:
                    begin
                        if (pos_reg == '0 && in_total < wph_pkg::MIN_FILE_BYTES)
                        begin
                            res = make_fail(wph_pkg::FAIL_SHORT);
                        end
                        else
                        begin
                            tag_next = tag_shift;
                            if (pos_reg == wph_pkg::LEN_W'(3) && tag_shift != wph_pkg::TAG_RIFF)
                            begin
                                res = make_fail(wph_pkg::FAIL_TAGS);
                            end
                            else if (pos_reg == wph_pkg::LEN_W'(11))
                            begin
                                if (tag_shift != wph_pkg::TAG_WAVE)
                                begin
                                    res = make_fail(wph_pkg::FAIL_TAGS);
                                end
                                else
                                begin
                                    phase_next = wph_pkg::PH_WAIT;
                                    ncs_next   = wph_pkg::FIRST_CHUNK;
                                end
                            end
                        end
                    end
                    wph_pkg::PH_WAIT, wph_pkg::PH_CHUNK_HDR:
                    begin
                        hdr = (phase_reg == wph_pkg::PH_CHUNK_HDR);
                        if (phase_reg == wph_pkg::PH_WAIT && pos_ext == {1'b0, ncs_reg})
                        begin
                            // need a full 8-byte chunk header inside the file
                            if (pay > total_ext)
                            begin
                                phase_next = wph_pkg::PH_IDLE;
                            end
                            else
                            begin
                                phase_next = wph_pkg::PH_CHUNK_HDR;
                                hdr        = 1'b1;
                            end
                        end
                        if (hdr)
                        begin
                            if (off < 3'd4)
                            begin
                                tag_next = tag_shift;
                            end
                            else
                            begin
                                len_next = len_shift;
                            end
                            if (off == 3'd7)
                            begin
                                if (chunk_end > total_ext)
                                begin
                                    res = make_fail(wph_pkg::FAIL_OVERRUN);
                                end
                                else if (tag_reg == wph_pkg::TAG_FMT
                                         && len_shift >= wph_pkg::FMT_MIN_BYTES)
                                begin
                                    phase_next = wph_pkg::PH_FMT;
                                end
                                else if (tag_reg == wph_pkg::TAG_DATA)
                                begin
                                    if (!pcm_reg)
                                    begin
                                        res = make_fail(wph_pkg::FAIL_NO_PCM);
                                    end
                                    else if (len_shift[31:1] == '0)
                                    begin
                                        res = make_fail(wph_pkg::FAIL_EMPTY);
                                    end
                                    else
                                    begin
                                        res.valid       = 1'b1;
                                        res.found       = 1'b1;
                                        res.fail_reason = wph_pkg::FAIL_NONE;
                                        res.data_offset = pay[wph_pkg::OFS_W-1:0];
                                        res.num_samples = len_shift[wph_pkg::CNT_W:1];
                                        res.rate_hz     = rate_reg;
                                    end
                                end
                                else
                                begin
                                    ncs_next   = hdr_start[wph_pkg::NCS_W-1:0];
                                    phase_next = wph_pkg::PH_WAIT;
                                end
                            end
                        end
                    end
                    wph_pkg::PH_FMT:
                    begin
                        // fmt payload: format, channels, rate, ..., bits per sample
                        case (fp)
                            4'd0:    ff_next[7:0]     = in_byte;
                            4'd1:    ff_next[15:8]    = in_byte;
                            4'd2:    ff_next[23:16]   = in_byte;
                            4'd3:    ff_next[31:24]   = in_byte;
                            4'd4:    rate_next[7:0]   = in_byte;
                            4'd5:    rate_next[15:8]  = in_byte;
                            4'd6:    rate_next[23:16] = in_byte;
                            4'd7:    rate_next[31:24] = in_byte;
                            4'd14:   ff_next[39:32]   = in_byte;
                            4'd15:   ff_next[47:40]   = in_byte;
                            default: ;
                        endcase
                        if (fp == 4'd15)
                        begin
                            pcm_next   = (ff_next[15:0] == 16'd1) && (ff_next[31:16] == 16'd1)
                                         && (ff_next[47:32] == 16'd16);
                            ncs_next   = fmt_start[wph_pkg::NCS_W-1:0];
                            phase_next = wph_pkg::PH_WAIT;
                        end
                    end
                    default: ;
                endcase
                if (res.valid)
                begin
                    verdict_next = 1'b1;
                    phase_next   = wph_pkg::PH_IDLE;
                end
            end

            if (&pos_reg)
            begin
                if (!verdict_next)
                begin
                    phase_next = wph_pkg::PH_IDLE;
                end
            end
            else
            begin
                pos_next = pos_reg + wph_pkg::LEN_W'(1);
            end

            if (in_last)
            begin
                if (!verdict_next)
                begin
                    res = make_fail((phase_next == wph_pkg::PH_HEADER) ?
                                    wph_pkg::FAIL_SHORT : wph_pkg::FAIL_NO_DATA);
                end
                pos_next     = '0;
                phase_next   = wph_pkg::PH_HEADER;
                tag_next     = '0;
                len_next     = '0;
                ncs_next     = wph_pkg::FIRST_CHUNK;
                ff_next      = '0;
                pcm_next     = 1'b0;
                rate_next    = '0;
                verdict_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            phase_reg   <= wph_pkg::PH_HEADER;
            tag_reg     <= '0;
            len_reg     <= '0;
            ncs_reg     <= wph_pkg::FIRST_CHUNK;
            ff_reg      <= '0;
            pcm_reg     <= 1'b0;
            rate_reg    <= '0;
            verdict_reg <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            phase_reg   <= phase_next;
            tag_reg     <= tag_next;
            len_reg     <= len_next;
            ncs_reg     <= ncs_next;
            ff_reg      <= ff_next;
            pcm_reg     <= pcm_next;
            rate_reg    <= rate_next;
            verdict_reg <= verdict_next;
        end
    end

    a_verdict_idle: assert property (@(posedge clk) disable iff (!rst_n)
        verdict_reg |-> phase_reg == wph_pkg::PH_IDLE)
        else $error("verdict given but parser not idle");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.found == (res.fail_reason == wph_pkg::FAIL_NONE)))
        else $error("found flag disagrees with fail reason");

    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        step && in_last |=> pos_reg == '0 && !verdict_reg && phase_reg == wph_pkg::PH_HEADER)
        else $error("state not cleared after last byte");

endmodule

`default_nettype wire

@@ rtl/core/wav_pcm_header_parser.sv @@
// Top level of the WAV PCM header parser: input register, parse core,
// result register. Depends on wph_pkg and wph_parse_core.
//
// Usage:
//   s_axis carries the file one byte per transaction; tdata holds the byte
//   and the total file length, tlast marks the final byte of the file.
//   m_axis carries at most one verdict per file: found flag, fail reason,
//   payload offset, sample count and sample rate.
//   Throughput: one byte per cycle unless a verdict waits on a stalled receiver;
//   set by the combinational step logic between the input and result registers.
//   A verdict is computed from the byte held in the input register and is
//   loaded into the result register, from which it is presented on m_axis.
//   Reset clears the parser to the start of a new file and empties both
//   registers. After the byte marked tlast the parser restarts as well.
//   When the receiver stalls with a verdict pending, the byte in the input
//   register waits and s_axis_tready drops until the verdict is taken.
`default_nettype none

module wav_pcm_header_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // data_byte[7:0], total_bytes[27:8], zero fill
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [79:0]      m_axis_tdata   // found[0], fail_reason[3:1], data_offset[23:4],
                                            // num_samples[42:24], rate_hz[74:43], zero fill
);

    logic                      in_valid_reg;
    logic [7:0]                in_byte_reg;
    logic [wph_pkg::LEN_W-1:0] in_total_reg;
    logic                      in_last_reg;
    logic                      advance;
    logic                      out_valid_reg;
    logic [74:0]               out_data_reg;
    wph_pkg::wph_result_t      res;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b00000, out_data_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg  <= s_axis_tdata[7:0];
            in_total_reg <= s_axis_tdata[27:8];
            in_last_reg  <= s_axis_tlast;
        end
    end

    wph_parse_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .in_byte  (in_byte_reg),
        .in_total (in_total_reg),
        .in_last  (in_last_reg),
        .res      (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && res.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.valid)
        begin
            out_data_reg <= {res.rate_hz, res.num_samples, res.data_offset,
                             res.fail_reason, res.found};
        end
    end

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg && out_valid_reg && !m_axis_tready)
        else $error("input stalled without a blocked verdict");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res.valid |=> out_valid_reg)
        else $error("verdict lost on the way to the result register");

    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg)
                                     && $stable(in_last_reg))
        else $error("waiting byte changed before it was processed");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Testbench for wav_pcm_header_parser: byte-stream WAV files in, one verdict per file out.
// Expected verdicts come from a built-in model of the parser. Depends on wph_pkg and the RTL.

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CYCLE_LIMIT         = 200_000;
    localparam int          RANDOM_BYTES        = 520;
    localparam int          MIN_RANDOM_VERDICTS = 12;
    localparam int          HOLD_CYCLES         = 400;
    localparam logic [19:0] FILE_MAX            = 20'hFFFFF;
    localparam logic [31:0] TAG_LIST            = 32'h5453_494C;
    localparam logic [15:0] FMT_PCM             = 16'd1;
    localparam logic [15:0] FMT_FLOAT           = 16'd3;
    localparam logic [15:0] MONO                = 16'd1;
    localparam logic [15:0] STEREO              = 16'd2;
    localparam logic [15:0] PCM_BITS            = 16'd16;

    typedef struct packed {
        logic                         found;
        logic [wph_pkg::REASON_W-1:0] reason;
        logic [wph_pkg::OFS_W-1:0]    offset;
        logic [wph_pkg::CNT_W-1:0]    count;
        logic [wph_pkg::RATE_W-1:0]   rate;
    } wav_verdict_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;

    wav_pcm_header_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 clk = ~clk;

    // parser model state
    logic [19:0] wav_pos;
    logic [2:0]  wav_phase;
    logic [31:0] wav_tag;
    logic [31:0] wav_len;
    logic [33:0] wav_next;
    logic [47:0] wav_fmt;     // format, channels, bits per sample
    logic        wav_pcm;
    logic [31:0] wav_rate;
    logic        wav_done;

    wav_verdict_t verdicts_due[$];
    wav_verdict_t got_v;
    wav_verdict_t want_v;
    logic [7:0]   wav_img[$];

    int n_fail     = 0;
    int n_parsed   = 0;
    int n_verdicts = 0;
    int cycle_count = 0;
    int hold_req   = 0;
    int stall_left = 0;
    bit idle_on    = 1'b1;

    task automatic wav_state_reset;
        wav_pos   = '0;
        wav_phase = wph_pkg::PH_HEADER;
        wav_tag   = '0;
        wav_len   = '0;
        wav_next  = wph_pkg::FIRST_CHUNK;
        wav_fmt   = '0;
        wav_pcm   = 1'b0;
        wav_rate  = '0;
        wav_done  = 1'b0;
    endtask

    task automatic give_verdict(input logic found, input logic [wph_pkg::REASON_W-1:0] reason,
                                input logic [wph_pkg::OFS_W-1:0] offset,
                                input logic [wph_pkg::CNT_W-1:0] count,
                                input logic [wph_pkg::RATE_W-1:0] rate);
        wav_verdict_t v;
        v = {found, reason, offset, count, rate};
        verdicts_due.push_back(v);
        wav_done  = 1'b1;
        wav_phase = wph_pkg::PH_IDLE;
        n_verdicts++;
    endtask

    task automatic close_chunk_header(input logic [19:0] total);
        logic [35:0] pay;
        logic [35:0] fin;
        pay = {2'b0, wav_next} + 36'd8;
        fin = pay + {4'd0, wav_len};   // full width, no wrap
        if (fin > {16'd0, total})
            give_verdict(1'b0, wph_pkg::FAIL_OVERRUN, '0, '0, '0);
        else if (wav_tag == wph_pkg::TAG_FMT && wav_len >= wph_pkg::FMT_MIN_BYTES)
            wav_phase = wph_pkg::PH_FMT;
        else if (wav_tag == wph_pkg::TAG_DATA)
        begin
            if (!wav_pcm)
                give_verdict(1'b0, wph_pkg::FAIL_NO_PCM, '0, '0, '0);
            else if (wav_len[31:1] == '0)
                give_verdict(1'b0, wph_pkg::FAIL_EMPTY, '0, '0, '0);
            else
                give_verdict(1'b1, wph_pkg::FAIL_NONE, pay[19:0], wav_len[19:1], wav_rate);
        end
        else
        begin
            wav_next  = fin[33:0] + {33'd0, wav_len[0]};
            wav_phase = wph_pkg::PH_WAIT;
        end
    endtask

    task automatic predict_wav_byte(input logic [7:0] b, input logic [19:0] total,
                                    input logic last);
        logic [33:0] off;
        int          ps;
        if (!wav_done)
        begin
            n_parsed++;
            if (wav_phase == wph_pkg::PH_HEADER)
            begin
                if (wav_pos == '0 && total < wph_pkg::MIN_FILE_BYTES)
                    give_verdict(1'b0, wph_pkg::FAIL_SHORT, '0, '0, '0);
                else
                begin
                    wav_tag = {b, wav_tag[31:8]};
                    if (wav_pos == 20'd3 && wav_tag != wph_pkg::TAG_RIFF)
                        give_verdict(1'b0, wph_pkg::FAIL_TAGS, '0, '0, '0);
                    else if (wav_pos == 20'd11)
                    begin
                        if (wav_tag != wph_pkg::TAG_WAVE)
                            give_verdict(1'b0, wph_pkg::FAIL_TAGS, '0, '0, '0);
                        else
                        begin
                            wav_phase = wph_pkg::PH_WAIT;
                            wav_next  = wph_pkg::FIRST_CHUNK;
                        end
                    end
                end
            end
            else
            begin
                if (wav_phase == wph_pkg::PH_WAIT && {14'd0, wav_pos} == wav_next)
                    wav_phase = ({1'b0, wav_next} + 35'd8 > {15'd0, total}) ?
                                wph_pkg::PH_IDLE : wph_pkg::PH_CHUNK_HDR;
                if (wav_phase == wph_pkg::PH_CHUNK_HDR)
                begin
                    off = {14'd0, wav_pos} - wav_next;
                    if (off < 34'd4)
                        wav_tag = {b, wav_tag[31:8]};
                    else
                        wav_len = {b, wav_len[31:8]};
                    if (off == 34'd7)
                        close_chunk_header(total);
                end
                else if (wav_phase == wph_pkg::PH_FMT)
                begin
                    off = {14'd0, wav_pos} - wav_next - 34'd8;
                    ps  = int'(off[3:0]);
                    if (off < 34'd4)
                        wav_fmt[ps*8 +: 8] = b;
                    else if (off < 34'd8)
                        wav_rate[(ps-4)*8 +: 8] = b;
                    else if (off == 34'd14 || off == 34'd15)
                        wav_fmt[32 + (ps-14)*8 +: 8] = b;
                    if (off == 34'd15)
                    begin
                        wav_pcm   = wav_fmt[15:0] == FMT_PCM && wav_fmt[31:16] == MONO
                                    && wav_fmt[47:32] == PCM_BITS;
                        wav_next  = wav_next + 34'd8 + {2'b0, wav_len} + {33'd0, wav_len[0]};
                        wav_phase = wph_pkg::PH_WAIT;
                    end
                end
            end
        end
        // position saturates; a byte at the limit stops parsing
        if (wav_pos == '1)
        begin
            if (!wav_done)
                wav_phase = wph_pkg::PH_IDLE;
        end
        else
            wav_pos = wav_pos + 20'd1;
        if (last)
        begin
            if (!wav_done)
                give_verdict(1'b0, wav_phase == wph_pkg::PH_HEADER ? wph_pkg::FAIL_SHORT
                                                                   : wph_pkg::FAIL_NO_DATA,
                             '0, '0, '0);
            wav_state_reset();
        end
    endtask

    // one byte transaction; model updated once the byte is taken
    task automatic send_byte(input logic [7:0] b, input logic [19:0] total, input logic last);
        while (idle_on && $urandom_range(0, 99) < 23)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, total, b};
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_wav_byte(b, total, last);
    endtask

    task automatic send_image(input logic [19:0] total, input int wobble_pct, input int alt_idx,
                              input logic [19:0] alt_total, input bit close);
        logic [19:0] t;
        for (int i = 0; i < wav_img.size(); i++)
        begin
            if (i == alt_idx)
                t = alt_total;
            else if ($urandom_range(0, 99) < wobble_pct)
                t = 20'($urandom);
            else
                t = total;
            send_byte(wav_img[i], t, close && i == wav_img.size() - 1);
        end
        wav_img.delete();
    endtask

    task automatic send_file(input logic [19:0] total);
        send_image(total, 0, -1, '0, 1'b1);
    endtask

    task automatic put_le(input logic [31:0] v, input int nbytes);
        for (int i = 0; i < nbytes; i++)
            wav_img.push_back(v[i*8 +: 8]);
    endtask

    task automatic put_fill(input int n);
        for (int i = 0; i < n; i++)
            wav_img.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic riff_head(input logic [31:0] first_tag, input logic [31:0] form_tag);
        put_le(first_tag, 4);
        put_le($urandom, 4);
        put_le(form_tag, 4);
    endtask

    task automatic put_chunk(input logic [31:0] tag, input logic [31:0] len);
        put_le(tag, 4);
        put_le(len, 4);
        put_fill(int'(len) + int'(len[0]));
    endtask

    task automatic put_fmt(input logic [31:0] len, input logic [15:0] code,
                           input logic [15:0] chans, input logic [31:0] rate,
                           input logic [15:0] bits);
        put_le(wph_pkg::TAG_FMT, 4);
        put_le(len, 4);
        put_le({16'd0, code}, 2);
        put_le({16'd0, chans}, 2);
        put_le(rate, 4);
        put_le($urandom, 4);   // byte rate, not checked
        put_le($urandom, 2);   // block align, not checked
        put_le({16'd0, bits}, 2);
        put_fill(int'(len) - 16 + int'(len[0]));
    endtask

    task automatic put_data_head(input logic [31:0] len);
        put_le(wph_pkg::TAG_DATA, 4);
        put_le(len, 4);
    endtask

    function automatic logic [15:0] mostly(input logic [15:0] usual);
        return ($urandom_range(0, 99) < 80) ? usual : 16'($urandom);
    endfunction

    // receiver: random stalls, plus a long hold on request
    always @(posedge clk)
    begin
        if (hold_req != 0)
        begin
            stall_left = hold_req;
            hold_req   = 0;
        end
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end
        else
            m_axis_tready <= !(idle_on && $urandom_range(0, 99) < 23);
    end

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            n_fail++;
        end
    endtask

    // tdata: found[0], fail_reason[3:1], data_offset[23:4], num_samples[42:24],
    // rate_hz[74:43]
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_v = {m_axis_tdata[0], m_axis_tdata[3:1], m_axis_tdata[23:4],
                     m_axis_tdata[42:24], m_axis_tdata[74:43]};
            if (verdicts_due.size() == 0)
            begin
                $display("%0t: unexpected verdict, expected none, actual found %0d reason %0d",
                         $time, got_v.found, got_v.reason);
                n_fail++;
            end
            else
            begin
                want_v = verdicts_due.pop_front();
                check_field("found", want_v.found, got_v.found);
                check_field("fail_reason", want_v.reason, got_v.reason);
                check_field("data_offset", want_v.offset, got_v.offset);
                check_field("num_samples", want_v.count, got_v.count);
                check_field("rate_hz", want_v.rate, got_v.rate);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic test_good_files;
        riff_head(wph_pkg::TAG_RIFF, wph_pkg::TAG_WAVE);
        put_fmt(16, FMT_PCM, MONO, 32'd44100, PCM_BITS);
        put_data_head(200);
        put_fill(4);
        send_file(20'd244);
        // largest file, all-ones rate, payload running to the very end
        riff_head(wph_pkg::TAG_RIFF, wph_pkg::TAG_WAVE);
        put_fmt(16, FMT_PCM, MONO, 32'hFFFF_FFFF, PCM_BITS);
        put_data_head(32'd1048531);
        put_le(32'h00FF_FFFF, 4);
        send_file(FILE_MAX);
        // odd unknown chunk, odd fmt, then a second fmt that wins
        riff_head(wph_pkg::TAG_RIFF, wph_pkg::TAG_WAVE);
        put_chunk(TAG_LIST, 5);
        put_fmt(17, FMT_PCM, STEREO, 32'd8000, PCM_BITS);
        put_fmt(18, FMT_PCM, MONO, 32'd22050, PCM_BITS);
        put_data_head(7);
        put_fill(2);
        send_file(20'(wav_img.size() + 5));
        // smallest non-empty data chunk
        riff_head(wph_pkg::TAG_RIFF, wph_pkg::TAG_WAVE);
        put_fmt(16, FMT_PCM, MONO, 32'd16000, PCM_BITS);
        put_data_head(2);
        put_fill(2);
        send_file(20'd46);
    endtask

    task automatic test_header_failures;
        riff_head(wph_pkg::TAG_RIFF, wph_pkg::TAG_WAVE);
        put_fmt(16, FMT_PCM, MONO, 32'd48000, PCM_BITS);
        put_data_head(10);
        send_file(20'd43);
        wav_img.push_back(8'hA5);
        send_file(20'd0);
        riff_head(wph_pkg::TAG_RIFF ^ 32'h8000_0000, wph_pkg::TAG_WAVE);
        put_fmt(16, FMT_PCM, MONO, 32'd48000, PCM_BITS);
        send_file(20'd100);
        riff_head(wph_pkg::TAG_RIFF, wph_pkg::TAG_WAVE ^ 32'h0000_0020);
        put_fmt(16, FMT_PCM, MONO, 32'd48000, PCM_BITS);
        send_file(20'd100);
        // stream ends inside the header, then right at its last byte
        put_fill(6);
        send_file(20'd100);
        riff_head(wph_pkg::TAG_RIFF, wph_pkg::TAG_WAVE);
        send_file(20'd100);
    endtask

    task automatic test_chunk_failures;
        riff_head(wph_pkg::TAG_RIFF, wph_pkg::TAG_WAVE);
        put_fmt(16, FMT_PCM, MONO, 32'd44100, PCM_BITS);
        put_data_head(32'hFFFF_FFFF);
        send_file(FILE_MAX);
        riff_head(wph_pkg::TAG_RIFF, wph_pkg::TAG_WAVE);
        put_le(TAG_LIST, 4);
        put_le(32'd200, 4);
        send_file(20'd100);
        riff_head(wph_pkg::TAG_RIFF, wph_pkg::TAG_WAVE);
        put_data_head(100);
        send_file(20'd200);
        riff_head(wph_pkg::TAG_RIFF, wph_pkg::TAG_WAVE);
        put_chunk(wph_pkg::TAG_FMT, 12);
        put_data_head(100);
        send_file(20'd200);
        riff_head(wph_pkg::TAG_RIFF, wph_pkg::TAG_WAVE);
        put_fmt(16, FMT_FLOAT, MONO, 32'd44100, PCM_BITS);
        put_data_head(100);
        send_file(20'd200);
        riff_head(wph_pkg::TAG_RIFF, wph_pkg::TAG_WAVE);
        put_fmt(16, FMT_PCM, MONO, 32'd44100, 16'd8);
        put_data_head(100);
        send_file(20'd200);
        riff_head(wph_pkg::TAG_RIFF, wph_pkg::TAG_WAVE);
        put_fmt(16, FMT_PCM, MONO, 32'd44100, PCM_BITS);
        put_data_head(1);
        put_fill(1);
        send_file(20'd46);
    endtask

    task automatic test_missing_data;
        riff_head(wph_pkg::TAG_RIFF, wph_pkg::TAG_WAVE);
        put_fmt(16, FMT_PCM, MONO, 32'd44100, PCM_BITS);
        put_chunk(TAG_LIST, 4);
        send_file(20'(wav_img.size()));
        // next chunk starts too close to the end for a header
        riff_head(wph_pkg::TAG_RIFF, wph_pkg::TAG_WAVE);
        put_fmt(16, FMT_PCM, MONO, 32'd44100, PCM_BITS);
        put_chunk(TAG_LIST, 0);
        put_fill(4);
        send_file(20'd50);
        riff_head(wph_pkg::TAG_RIFF, wph_pkg::TAG_WAVE);
        put_fmt(16, FMT_PCM, MONO, 32'd44100, PCM_BITS);
        wav_img = wav_img[0:19];
        send_file(20'd100);
        riff_head(wph_pkg::TAG_RIFF, wph_pkg::TAG_WAVE);
        put_chunk(TAG_LIST, 4);
        wav_img = wav_img[0:15];
        send_file(20'd100);
    endtask

    task automatic test_total_changes;
        for (int i = 0; i < 4; i++)
        begin
            riff_head(wph_pkg::TAG_RIFF, wph_pkg::TAG_WAVE);
            put_fmt(16, FMT_PCM, MONO, 32'd32000, PCM_BITS);
            put_data_head(200);
            put_fill(2);
            case (i)
                0: send_image(20'd244, 0, 0, 20'd43, 1'b1);
                1: send_image(20'd244, 0, 43, 20'd100, 1'b1);
                2: send_image(20'd244, 0, 12, 20'd19, 1'b1);
                default: send_image(20'd244, 50, -1, '0, 1'b1);
            endcase
        end
    endtask

    task automatic test_back_to_back;
        idle_on = 1'b0;
        riff_head(wph_pkg::TAG_RIFF, wph_pkg::TAG_WAVE);
        put_fmt(16, FMT_PCM, MONO, 32'd11025, PCM_BITS);
        put_data_head(64);
        send_file(20'd108);
        wav_img.push_back(8'h00);
        send_file(20'd7);
        riff_head(wph_pkg::TAG_RIFF, wph_pkg::TAG_WAVE);
        put_fmt(16, FMT_PCM, MONO, 32'd96000, PCM_BITS);
        put_data_head(30);
        send_file(20'd74);
        idle_on = 1'b1;
    endtask

    // receiver holds off while one-byte files keep producing verdicts
    task automatic test_receiver_hold;
        hold_req = HOLD_CYCLES;
        for (int i = 0; i < 40; i++)
        begin
            wav_img.push_back(8'($urandom_range(0, 255)));
            send_file(20'($urandom_range(0, 43)));
        end
        riff_head(wph_pkg::TAG_RIFF, wph_pkg::TAG_WAVE);
        put_fmt(16, FMT_PCM, MONO, 32'd44100, PCM_BITS);
        put_data_head(88);
        send_file(20'd132);
    endtask

    task automatic random_wav_file;
        int          n;
        int          pay;
        int          r;
        logic [63:0] dlen;
        logic [63:0] tot;
        if ($urandom_range(0, 99) < 8)
        begin
            put_fill($urandom_range(1, 60));
            send_image(20'($urandom), 30, -1, '0, 1'b1);
            return;
        end
        riff_head(wph_pkg::TAG_RIFF, wph_pkg::TAG_WAVE);
        n = $urandom_range(0, 2);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 4) == 0)
                put_chunk(wph_pkg::TAG_FMT, $urandom_range(0, 15));
            else
                put_chunk($urandom, $urandom_range(0, 9));
        end
        if ($urandom_range(0, 99) < 85)
        begin
            case ($urandom_range(0, 4))
                0: r = 8000;
                1: r = 16000;
                2: r = 44100;
                3: r = 48000;
                default: r = int'($urandom);
            endcase
            put_fmt(16 + $urandom_range(0, 4), mostly(FMT_PCM), mostly(MONO), r,
                    mostly(PCM_BITS));
        end
        if ($urandom_range(0, 9) == 0)
            put_chunk($urandom, $urandom_range(0, 6));
        if ($urandom_range(0, 99) < 90)
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
                dlen = $urandom_range(0, 1);
            else if (r < 50)
                dlen = $urandom_range(2, 64);
            else if (r < 95)
                dlen = $urandom_range(0, int'(FILE_MAX) - wav_img.size() - 8);
            else
                dlen = {32'd0, $urandom};
            put_data_head(dlen[31:0]);
            pay = wav_img.size();
            put_fill($urandom_range(0, 4));
            tot = pay + dlen + $urandom_range(0, 3);
        end
        else
            tot = wav_img.size() + $urandom_range(0, 20);
        if (tot > FILE_MAX)
            tot = FILE_MAX;
        if (tot < 44 && $urandom_range(0, 3) != 0)
            tot = 44 + $urandom_range(0, 20);
        if ($urandom_range(0, 9) == 0)
            tot = $urandom_range(0, int'(FILE_MAX));
        if ($urandom_range(0, 99) < 7)
        begin
            r = $urandom_range(0, wav_img.size() - 1);
            wav_img[r] = wav_img[r] ^ 8'($urandom_range(1, 255));
        end
        if ($urandom_range(0, 99) < 7)
        begin
            n = $urandom_range(1, wav_img.size());
            while (wav_img.size() > n)
                void'(wav_img.pop_back());
        end
        send_image(tot[19:0], ($urandom_range(0, 99) < 5) ? 30 : 0, -1, '0, 1'b1);
    endtask

    task automatic test_random_files;
        int parsed0;
        int verdicts0;
        parsed0   = n_parsed;
        verdicts0 = n_verdicts;
        while (n_parsed - parsed0 < RANDOM_BYTES || n_verdicts - verdicts0 < MIN_RANDOM_VERDICTS)
            random_wav_file();
    endtask

    initial
    begin
        wav_state_reset();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_good_files();
        test_header_failures();
        test_chunk_failures();
        test_missing_data();
        test_total_changes();
        test_back_to_back();
        test_receiver_hold();
        test_random_files();
        s_axis_tvalid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);   // catch any stray verdict after the last one
        if (n_fail == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
